@@ rtl/lfps_pkg.sv @@
`timescale 1ns / 1ps

package lfps_pkg;

    // Base PWM values of the fast profile, whole percent.
    localparam int FAST_STRAIGHT_L = 42;
    localparam int FAST_STRAIGHT_R = 45;
    localparam int FAST_CURVE_L    = 36;
    localparam int FAST_CURVE_R    = 39;

    // Target base PWM values of the balance profile, whole percent.
    localparam int BAL_STRAIGHT_L = 25;
    localparam int BAL_STRAIGHT_R = 28;
    localparam int BAL_CURVE_L    = 25;
    localparam int BAL_CURVE_R    = 28;

    // Duty cycles used to swing back toward a lost line.
    localparam int LOST_HIGH_PWM = 18;
    localparam int LOST_LOW_PWM  = 5;

    // Confirm counts of the curve detector.
    localparam int ENTER_CONFIRM = 10;
    localparam int EXIT_CONFIRM  = 25;

    // Configuration register indexes.
    localparam logic [2:0] REG_SPEED_PROFILE = 3'd0;
    localparam logic [2:0] REG_KP_GAIN       = 3'd1;
    localparam logic [2:0] REG_KD_GAIN       = 3'd2;
    localparam logic [2:0] REG_CURVE_THRESH  = 3'd3;
    localparam logic [2:0] REG_STEER_LIMIT   = 3'd4;
    localparam logic [2:0] REG_TURN_SLEW     = 3'd5;
    localparam logic [2:0] REG_LOST_TIMEOUT  = 3'd6;
    localparam logic [2:0] REG_STEER_NEGATE  = 3'd7;

    // Position weight of each sensor, leftmost sensor first.
    function automatic logic signed [4:0] sensor_weight(input logic [2:0] idx);
        logic signed [4:0] w;
        case (idx)
            3'd0:    w = -5'sd7;
            3'd1:    w = -5'sd5;
            3'd2:    w = -5'sd3;
            3'd3:    w = -5'sd1;
            3'd4:    w = 5'sd1;
            3'd5:    w = 5'sd3;
            3'd6:    w = 5'sd5;
            default: w = 5'sd7;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/lfps_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, rounding to nearest.
module lfps_div #(
    parameter int NW = 31,
    parameter int DW = 22
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb begin
        trial    = {rem_reg, quo_reg[NW-1]};
        ge       = (trial >= {1'b0, den});
        rem_next = ge ? DW'(trial - {1'b0, den}) : DW'(trial);
    end

    // Half the divisor is added up front so that the floor rounds to nearest.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(1));
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= num + NW'(den >> 1);
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/line_follow_pd_steering_unit.sv @@
`timescale 1ns / 1ps

// A lost-line or fault request needs no division. A line request divides for the
// line error (FRAC_BITS + 23 quotient bits); the balance profile divides again for the
// wheel difference, unless the weighted sum of the wheel speed magnitudes is below 140.
// One request is handled at a time; s_tready returns in the cycle after the result is loaded.
// Reset: synchronous, active low; it restores the register defaults and clears
// the steering history, the lost counter, the fault latch and the curve detector.
module line_follow_pd_steering_unit
    import lfps_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // black_mask [7:0], left_speed [23:8], right_speed [39:24]
    input  logic [39:0]                            s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // left_pwm, right_pwm, line_valid, steer_term, curve_active, fault
    output logic [((FRAC_BITS + 32) / 8) * 8 - 1:0] m_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [2:0]                             cfg_index,
    input  logic [11:0]                            cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int EW  = F + 4;
    localparam int TW  = F + 8;
    localparam int FW  = F + 8;
    localparam int PW  = F + 20;
    localparam int SW  = F + 9;
    localparam int BW  = F + 7;
    localparam int DNW = F + 23;
    localparam int DDW = 22;
    localparam int ODW = ((F + 32) / 8) * 8;

    localparam int Q_FE_ENTER = ((140 << F) + 50) / 100;
    localparam int Q_FT_ENTER = ((250 << F) + 50) / 100;
    localparam int Q_FW_ENTER = ((18 << F) + 50) / 100;
    localparam int Q_FE_EXIT  = ((80 << F) + 50) / 100;
    localparam int Q_FT_EXIT  = ((120 << F) + 50) / 100;
    localparam int Q_FW_EXIT  = ((10 << F) + 50) / 100;
    localparam int Q_STEP     = ((11 << F) + 50) / 100;

    // Reciprocal of five, exact for every filter step magnitude.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_5     = ((1 << RECIP_SHIFT) + 4) / 5;

    localparam logic signed [PW-1:0] PD_HALF   = PW'(1) << (F - 1);
    localparam logic signed [BW-1:0] BASE_HALF = BW'(1) << (F - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLASS = 4'd1;
    localparam logic [3:0] ST_ERR   = 4'd2;
    localparam logic [3:0] ST_PD    = 4'd3;
    localparam logic [3:0] ST_PD2   = 4'd4;
    localparam logic [3:0] ST_TURN  = 4'd5;
    localparam logic [3:0] ST_WD    = 4'd6;
    localparam logic [3:0] ST_WDW   = 4'd7;
    localparam logic [3:0] ST_FE    = 4'd8;
    localparam logic [3:0] ST_FT    = 4'd9;
    localparam logic [3:0] ST_FW    = 4'd10;
    localparam logic [3:0] ST_DET   = 4'd11;
    localparam logic [3:0] ST_BASE  = 4'd12;
    localparam logic [3:0] ST_FIN   = 4'd13;
    localparam logic [3:0] ST_OUT   = 4'd14;

    // Configuration registers.
    logic        speed_profile_reg;
    logic [11:0] kp_gain_reg;
    logic [11:0] kd_gain_reg;
    logic [10:0] curve_thresh_reg;
    logic [6:0]  steer_limit_reg;
    logic [6:0]  turn_slew_reg;
    logic [7:0]  lost_timeout_reg;
    logic        steer_negate_reg;

    // Control state carried from tick to tick.
    logic [3:0]           state_reg;
    logic signed [EW-1:0] prev_error_reg;
    logic signed [TW-1:0] prev_turn_reg;
    logic [7:0]           lost_count_reg;
    logic                 fault_reg;
    logic                 curve_reg;
    logic [3:0]           enter_count_reg;
    logic [4:0]           exit_count_reg;
    logic signed [FW-1:0] filt_error_reg;
    logic signed [FW-1:0] filt_turn_reg;
    logic signed [FW-1:0] filt_wd_reg;
    logic signed [BW-1:0] base_left_reg;
    logic signed [BW-1:0] base_right_reg;

    // Per-request working registers.
    logic [7:0]           mask_reg;
    logic signed [15:0]   ls_reg;
    logic signed [15:0]   rs_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [PW-1:0] pd_reg;
    logic signed [TW-1:0] turn_reg;
    logic signed [FW-1:0] wd_reg;

    // Divider request.
    logic             div_start_reg;
    logic [DNW-1:0]   div_num_reg;
    logic [DDW-1:0]   div_den_reg;
    logic             div_neg_reg;
    logic             div_done;
    logic [DNW-1:0]   div_quo;

    // Result register.
    logic [6:0]           res_left_reg;
    logic [6:0]           res_right_reg;
    logic                 res_valid_reg;
    logic signed [TW-1:0] res_steer_reg;
    logic                 res_curve_reg;
    logic                 res_fault_reg;
    logic                 m_tvalid_reg;
    logic [ODW-1:0]       m_tdata_reg;

    lfps_div #(
        .NW (DNW),
        .DW (DDW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Sensor sum and count.
    logic signed [5:0] sum_c;
    logic [3:0]        cnt_c;
    logic [4:0]        sum_abs_c;

    always_comb begin
        sum_c = '0;
        cnt_c = '0;
        for (int i = 0; i < 8; i++) begin
            if (mask_reg[i]) begin
                sum_c = sum_c + 6'(sensor_weight(3'(i)));
                cnt_c = cnt_c + 4'd1;
            end
        end
        sum_abs_c = sum_c[5] ? 5'(-sum_c) : 5'(sum_c);
    end

    // Lost-line counter.
    logic [7:0] lost_next_c;
    assign lost_next_c = (lost_count_reg == 8'hFF) ? 8'hFF : lost_count_reg + 8'd1;

    // Error as a signed quotient, and its magnitude.
    logic signed [EW-1:0] err_q_c;
    logic [EW-1:0]        abs_err_c;
    logic [TW-1:0]        abs_turn_c;

    always_comb begin
        err_q_c    = div_neg_reg ? -EW'(div_quo) : EW'(div_quo);
        abs_err_c  = err_reg[EW-1] ? EW'(-err_reg) : EW'(err_reg);
        abs_turn_c = turn_reg[TW-1] ? TW'(-turn_reg) : TW'(turn_reg);
    end

    // Shared multiplier for the two PD products.
    logic signed [PW-1:0] mul_a_c;
    logic signed [PW-1:0] mul_b_c;
    logic signed [PW-1:0] mul_p_c;

    always_comb begin
        if (state_reg == ST_PD) begin
            mul_a_c = signed'(PW'(kp_gain_reg));
            mul_b_c = PW'(err_reg);
        end else begin
            mul_a_c = signed'(PW'(kd_gain_reg));
            mul_b_c = PW'(err_reg) - PW'(prev_error_reg);
        end
        mul_p_c = mul_a_c * mul_b_c;
    end

    // Rounding, optional negation, clamp and slew of the PD term.
    logic signed [PW-1:0] pr_c;
    logic signed [PW-1:0] pn_c;
    logic signed [PW-1:0] lim1_c;
    logic signed [PW-1:0] t1_c;
    logic signed [SW-1:0] t1s_c;
    logic signed [SW-1:0] prev_s_c;
    logic signed [SW-1:0] lim2_c;
    logic signed [SW-1:0] lo_c;
    logic signed [SW-1:0] hi_c;
    logic signed [SW-1:0] t2_c;
    logic signed [TW-1:0] turn_c;

    always_comb begin
        if (pd_reg[PW-1]) begin
            pr_c = -((-pd_reg + PD_HALF) >>> F);
        end else begin
            pr_c = (pd_reg + PD_HALF) >>> F;
        end
        pn_c   = steer_negate_reg ? -pr_c : pr_c;
        lim1_c = signed'(PW'({steer_limit_reg, {F{1'b0}}}));
        if (pn_c < -lim1_c) begin
            t1_c = -lim1_c;
        end else if (pn_c > lim1_c) begin
            t1_c = lim1_c;
        end else begin
            t1_c = pn_c;
        end
        t1s_c    = SW'(t1_c);
        prev_s_c = SW'(prev_turn_reg);
        lim2_c   = signed'(SW'({turn_slew_reg, {F{1'b0}}}));
        lo_c     = prev_s_c - lim2_c;
        hi_c     = prev_s_c + lim2_c;
        if (t1s_c < lo_c) begin
            t2_c = lo_c;
        end else if (t1s_c > hi_c) begin
            t2_c = hi_c;
        end else begin
            t2_c = t1s_c;
        end
        turn_c = TW'(t2_c);
    end

    // Wheel difference operands.
    logic signed [20:0] wa_c;
    logic signed [20:0] wb_c;
    logic [20:0]        wa_abs_c;
    logic [20:0]        wb_abs_c;
    logic [21:0]        ws_c;
    logic signed [21:0] wd_c;
    logic [21:0]        wd_abs_c;

    always_comb begin
        wa_c     = 21'(ls_reg) * 21'sd28;
        wb_c     = 21'(rs_reg) * 21'sd25;
        wa_abs_c = wa_c[20] ? 21'(-wa_c) : 21'(wa_c);
        wb_abs_c = wb_c[20] ? 21'(-wb_c) : 21'(wb_c);
        ws_c     = 22'(wa_abs_c) + 22'(wb_abs_c);
        wd_c     = 22'(wa_c) - 22'(wb_c);
        wd_abs_c = wd_c[21] ? 22'(-wd_c) : 22'(wd_c);
    end

    // The divider is launched for the line error and for the wheel difference.
    logic div_launch_c;
    assign div_launch_c = ((state_reg == ST_CLASS) && !fault_reg && (cnt_c != 4'd0))
                       || ((state_reg == ST_WD) && (ws_c >= 22'd140));

    // Filter step (x - f) / 5, rounded to nearest, by reciprocal multiplication.
    logic signed [FW:0]   fd_c;
    logic [FW:0]          fd_abs_c;
    logic [FW+22:0]       fq_prod_c;
    logic signed [FW:0]   fq_c;
    logic signed [FW-1:0] fnew_c;
    logic signed [FW-1:0] fold_c;

    always_comb begin
        case (state_reg)
            ST_FT: begin
                fd_c   = signed'((FW + 1)'(abs_turn_c)) - (FW + 1)'(filt_turn_reg);
                fold_c = filt_turn_reg;
            end
            ST_FW: begin
                fd_c   = (FW + 1)'(wd_reg) - (FW + 1)'(filt_wd_reg);
                fold_c = filt_wd_reg;
            end
            default: begin
                fd_c   = signed'((FW + 1)'(abs_err_c)) - (FW + 1)'(filt_error_reg);
                fold_c = filt_error_reg;
            end
        endcase
        fd_abs_c  = fd_c[FW] ? (FW + 1)'(-fd_c) : (FW + 1)'(fd_c);
        fq_prod_c = (FW + 23)'(fd_abs_c + (FW + 1)'(2)) * (FW + 23)'(RECIP_5);
        fq_c      = signed'((FW + 1)'(fq_prod_c >> RECIP_SHIFT));
        fnew_c    = FW'((FW + 1)'(fold_c) + (fd_c[FW] ? -fq_c : fq_c));
    end

    // Curve detector conditions.
    logic ev_enter_c;
    logic ev_exit_c;

    always_comb begin
        ev_enter_c = (filt_error_reg >= signed'(FW'(Q_FE_ENTER)))
                  || (filt_turn_reg >= signed'(FW'(Q_FT_ENTER)))
                  || (filt_wd_reg >= signed'(FW'(Q_FW_ENTER)));
        ev_exit_c  = (filt_error_reg <= signed'(FW'(Q_FE_EXIT)))
                  && (filt_turn_reg <= signed'(FW'(Q_FT_EXIT)))
                  && (filt_wd_reg <= signed'(FW'(Q_FW_EXIT)));
    end

    // Slewed bases of the balance profile.
    logic signed [BW-1:0] tl_c;
    logic signed [BW-1:0] tr_c;
    logic signed [BW-1:0] bl_next_c;
    logic signed [BW-1:0] br_next_c;

    always_comb begin
        tl_c = curve_reg ? signed'(BW'(BAL_CURVE_L << F)) : signed'(BW'(BAL_STRAIGHT_L << F));
        tr_c = curve_reg ? signed'(BW'(BAL_CURVE_R << F)) : signed'(BW'(BAL_STRAIGHT_R << F));
        if (tl_c < base_left_reg - BW'(Q_STEP)) begin
            bl_next_c = base_left_reg - BW'(Q_STEP);
        end else if (tl_c > base_left_reg + BW'(Q_STEP)) begin
            bl_next_c = base_left_reg + BW'(Q_STEP);
        end else begin
            bl_next_c = tl_c;
        end
        if (tr_c < base_right_reg - BW'(Q_STEP)) begin
            br_next_c = base_right_reg - BW'(Q_STEP);
        end else if (tr_c > base_right_reg + BW'(Q_STEP)) begin
            br_next_c = base_right_reg + BW'(Q_STEP);
        end else begin
            br_next_c = tr_c;
        end
    end

    // Final PWM: base plus or minus the whole part of the steering term.
    logic signed [BW-1:0] rl_full_c;
    logic signed [BW-1:0] rr_full_c;
    logic [6:0]           rnd_l_c;
    logic [6:0]           rnd_r_c;
    logic [6:0]           bl_c;
    logic [6:0]           br_c;
    logic signed [TW-1:0] ti_full_c;
    logic signed [9:0]    ti_c;
    logic signed [9:0]    lsum_c;
    logic signed [9:0]    rsum_c;
    logic [6:0]           left_c;
    logic [6:0]           right_c;

    always_comb begin
        rl_full_c = (base_left_reg + BASE_HALF) >>> F;
        rr_full_c = (base_right_reg + BASE_HALF) >>> F;
        if (base_left_reg <= 0) begin
            rnd_l_c = 7'd0;
        end else if (rl_full_c > 100) begin
            rnd_l_c = 7'd100;
        end else begin
            rnd_l_c = 7'(rl_full_c);
        end
        if (base_right_reg <= 0) begin
            rnd_r_c = 7'd0;
        end else if (rr_full_c > 100) begin
            rnd_r_c = 7'd100;
        end else begin
            rnd_r_c = 7'(rr_full_c);
        end
        if (speed_profile_reg) begin
            bl_c = rnd_l_c;
            br_c = rnd_r_c;
        end else if (abs_err_c >= EW'(curve_thresh_reg)) begin
            bl_c = 7'(FAST_CURVE_L);
            br_c = 7'(FAST_CURVE_R);
        end else begin
            bl_c = 7'(FAST_STRAIGHT_L);
            br_c = 7'(FAST_STRAIGHT_R);
        end
        ti_full_c = turn_reg[TW-1] ? -((-turn_reg) >>> F) : (turn_reg >>> F);
        ti_c      = 10'(ti_full_c);
        lsum_c    = signed'(10'(bl_c)) + ti_c;
        rsum_c    = signed'(10'(br_c)) - ti_c;
        left_c    = (lsum_c < 0) ? 7'd0 : ((lsum_c > 100) ? 7'd100 : 7'(lsum_c));
        right_c   = (rsum_c < 0) ? 7'd0 : ((rsum_c > 100) ? 7'd100 : 7'(rsum_c));
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_profile_reg <= 1'b0;
            kp_gain_reg       <= 12'd461;
            kd_gain_reg       <= 12'd38;
            curve_thresh_reg  <= 11'd461;
            steer_limit_reg   <= 7'd20;
            turn_slew_reg     <= 7'd4;
            lost_timeout_reg  <= 8'd20;
            steer_negate_reg  <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SPEED_PROFILE: speed_profile_reg <= cfg_data[0];
                REG_KP_GAIN:       kp_gain_reg       <= cfg_data;
                REG_KD_GAIN:       kd_gain_reg       <= cfg_data;
                REG_CURVE_THRESH:  curve_thresh_reg  <= cfg_data[10:0];
                REG_STEER_LIMIT:   steer_limit_reg   <= cfg_data[6:0];
                REG_TURN_SLEW:     turn_slew_reg     <= cfg_data[6:0];
                REG_LOST_TIMEOUT:  lost_timeout_reg  <= cfg_data[7:0];
                REG_STEER_NEGATE:  steer_negate_reg  <= cfg_data[0];
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            prev_error_reg  <= '0;
            prev_turn_reg   <= '0;
            lost_count_reg  <= '0;
            fault_reg       <= 1'b0;
            curve_reg       <= 1'b0;
            enter_count_reg <= '0;
            exit_count_reg  <= '0;
            filt_error_reg  <= '0;
            filt_turn_reg   <= '0;
            filt_wd_reg     <= '0;
            base_left_reg   <= signed'(BW'(BAL_STRAIGHT_L << F));
            base_right_reg  <= signed'(BW'(BAL_STRAIGHT_R << F));
            div_start_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            div_start_reg <= div_launch_c;
            // Output register: loaded from the result registers, freed once taken.
            if ((state_reg == ST_OUT) && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mask_reg  <= s_tdata[7:0];
                        ls_reg    <= signed'(s_tdata[23:8]);
                        rs_reg    <= signed'(s_tdata[39:24]);
                        state_reg <= ST_CLASS;
                    end
                end
                ST_CLASS: begin
                    res_valid_reg <= 1'b0;
                    if (fault_reg) begin
                        res_left_reg  <= '0;
                        res_right_reg <= '0;
                        res_steer_reg <= '0;
                        res_curve_reg <= 1'b0;
                        res_fault_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end else if (cnt_c == 4'd0) begin
                        lost_count_reg <= lost_next_c;
                        if (lost_next_c > lost_timeout_reg) begin
                            fault_reg     <= 1'b1;
                            res_left_reg  <= '0;
                            res_right_reg <= '0;
                            res_steer_reg <= '0;
                            res_curve_reg <= 1'b0;
                            res_fault_reg <= 1'b1;
                        end else begin
                            res_steer_reg <= prev_turn_reg;
                            res_curve_reg <= curve_reg;
                            res_fault_reg <= 1'b0;
                            if (prev_error_reg > 0) begin
                                res_left_reg  <= 7'(LOST_HIGH_PWM);
                                res_right_reg <= 7'(LOST_LOW_PWM);
                            end else if (prev_error_reg < 0) begin
                                res_left_reg  <= 7'(LOST_LOW_PWM);
                                res_right_reg <= 7'(LOST_HIGH_PWM);
                            end else begin
                                res_left_reg  <= '0;
                                res_right_reg <= '0;
                            end
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        lost_count_reg <= '0;
                        div_num_reg    <= DNW'({sum_abs_c, {F{1'b0}}});
                        div_den_reg    <= DDW'(cnt_c);
                        div_neg_reg    <= sum_c[5];
                        state_reg      <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    if (div_done) begin
                        err_reg   <= err_q_c;
                        state_reg <= ST_PD;
                    end
                end
                ST_PD: begin
                    pd_reg    <= mul_p_c;
                    state_reg <= ST_PD2;
                end
                ST_PD2: begin
                    pd_reg    <= pd_reg + mul_p_c;
                    state_reg <= ST_TURN;
                end
                ST_TURN: begin
                    turn_reg  <= turn_c;
                    state_reg <= speed_profile_reg ? ST_WD : ST_FIN;
                end
                ST_WD: begin
                    if (ws_c < 22'd140) begin
                        wd_reg    <= '0;
                        state_reg <= ST_FE;
                    end else begin
                        div_num_reg <= DNW'({wd_abs_c, {(F + 1){1'b0}}});
                        div_den_reg <= ws_c;
                        div_neg_reg <= 1'b0;
                        state_reg   <= ST_WDW;
                    end
                end
                ST_WDW: begin
                    if (div_done) begin
                        wd_reg    <= FW'(div_quo);
                        state_reg <= ST_FE;
                    end
                end
                ST_FE: begin
                    filt_error_reg <= fnew_c;
                    state_reg      <= ST_FT;
                end
                ST_FT: begin
                    filt_turn_reg <= fnew_c;
                    state_reg     <= ST_FW;
                end
                ST_FW: begin
                    filt_wd_reg <= fnew_c;
                    state_reg   <= ST_DET;
                end
                ST_DET: begin
                    // Confirm counters: a curve must be seen, or left, for a run of ticks.
                    if (!curve_reg) begin
                        exit_count_reg <= '0;
                        if (ev_enter_c) begin
                            if (enter_count_reg >= 4'(ENTER_CONFIRM - 1)) begin
                                curve_reg       <= 1'b1;
                                enter_count_reg <= '0;
                            end else begin
                                enter_count_reg <= enter_count_reg + 4'd1;
                            end
                        end else begin
                            enter_count_reg <= '0;
                        end
                    end else begin
                        enter_count_reg <= '0;
                        if (ev_exit_c) begin
                            if (exit_count_reg >= 5'(EXIT_CONFIRM - 1)) begin
                                curve_reg      <= 1'b0;
                                exit_count_reg <= '0;
                            end else begin
                                exit_count_reg <= exit_count_reg + 5'd1;
                            end
                        end else begin
                            exit_count_reg <= '0;
                        end
                    end
                    state_reg <= ST_BASE;
                end
                ST_BASE: begin
                    base_left_reg  <= bl_next_c;
                    base_right_reg <= br_next_c;
                    state_reg      <= ST_FIN;
                end
                ST_FIN: begin
                    res_left_reg   <= left_c;
                    res_right_reg  <= right_c;
                    res_valid_reg  <= 1'b1;
                    res_steer_reg  <= turn_reg;
                    res_curve_reg  <= curve_reg;
                    res_fault_reg  <= 1'b0;
                    prev_turn_reg  <= turn_reg;
                    prev_error_reg <= err_reg;
                    state_reg      <= ST_OUT;
                end
                ST_OUT: begin
                    // Hand the result over once the output register is free.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= ODW'({res_fault_reg, res_curve_reg, res_steer_reg,
                                              res_valid_reg, res_right_reg, res_left_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import lfps_pkg::*;

    localparam int  QF          = 8;
    localparam longint ONE      = 256;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  DRAIN       = 200;

    typedef struct packed {
        logic        fault;
        logic        curve;
        logic [15:0] steer;
        logic        valid;
        logic [6:0]  right;
        logic [6:0]  left;
    } steer_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    line_follow_pd_steering_unit #(.FRAC_BITS(QF)) u_dut (.*);

    // Clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Copy of the configuration registers.
    int unsigned profile_r, kp_r, kd_r, thresh_r, limit_r, slew_r, timeout_r, negate_r;

    // Steering and detector state.
    longint prev_err, prev_turn, filt_e, filt_t, filt_w, base_l, base_r;
    int     lost_cnt, enter_c, exit_c;
    bit     fault_l, curve_f;

    steer_out_t expected_q[$];
    int  mismatches = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_requests = 0;
    int  pos = 3;

    function automatic longint round_div(longint num, longint den);
        if (num < 0) return -((-num + den / 2) / den);
        return (num + den / 2) / den;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint pct_q(longint n);
        return ((n << QF) + 50) / 100;
    endfunction

    function automatic longint base_pwm(longint v);
        if (v <= 0) return 0;
        return clampv((v + ONE / 2) / ONE, 0, 100);
    endfunction

    function automatic longint wheel_skew(longint ls, longint rs);
        longint a, b, s;
        a = 28 * ls;
        b = 25 * rs;
        s = mag(a) + mag(b);
        if (s < 140) return 0;
        return round_div(mag(a - b) * 2 * ONE, s);
    endfunction

    function automatic steer_out_t pack_out(longint l, longint r, bit v, longint st,
                                            bit c, bit f);
        steer_out_t o;
        o.left  = l[6:0];
        o.right = r[6:0];
        o.valid = v;
        o.steer = st[15:0];
        o.curve = c;
        o.fault = f;
        return o;
    endfunction

    // Balance-profile curve detector and base slewing.
    function automatic void update_detector(longint err, longint turn, longint ls, longint rs);
        longint step, tl, tr;
        bit ev;
        step = pct_q(11);
        filt_e += round_div(mag(err) - filt_e, 5);
        filt_t += round_div(mag(turn) - filt_t, 5);
        filt_w += round_div(wheel_skew(ls, rs) - filt_w, 5);
        if (!curve_f) begin
            ev = filt_e >= pct_q(140) || filt_t >= pct_q(250) || filt_w >= pct_q(18);
            exit_c = 0;
            if (ev) begin
                if (enter_c < ENTER_CONFIRM) enter_c++;
                if (enter_c >= ENTER_CONFIRM) begin
                    curve_f = 1;
                    enter_c = 0;
                end
            end else begin
                enter_c = 0;
            end
        end else begin
            ev = filt_e <= pct_q(80) && filt_t <= pct_q(120) && filt_w <= pct_q(10);
            enter_c = 0;
            if (ev) begin
                if (exit_c < EXIT_CONFIRM) exit_c++;
                if (exit_c >= EXIT_CONFIRM) begin
                    curve_f = 0;
                    exit_c = 0;
                end
            end else begin
                exit_c = 0;
            end
        end
        tl = longint'(curve_f ? BAL_CURVE_L : BAL_STRAIGHT_L) * ONE;
        tr = longint'(curve_f ? BAL_CURVE_R : BAL_STRAIGHT_R) * ONE;
        base_l = clampv(tl, base_l - step, base_l + step);
        base_r = clampv(tr, base_r - step, base_r + step);
    endfunction

    // Works out the motor command of one control tick.
    function automatic steer_out_t steer_tick(logic [7:0] mask, longint ls, longint rs);
        longint sum, cnt, err, pd, turn, lim, bl, br, ti;
        sum = 0;
        cnt = 0;
        if (fault_l) return pack_out(0, 0, 0, 0, 0, 1);
        for (int i = 0; i < 8; i++) begin
            if (mask[i]) begin
                sum += 2 * i - 7;
                cnt++;
            end
        end
        if (cnt == 0) begin
            if (lost_cnt < 255) lost_cnt++;
            if (lost_cnt > timeout_r) begin
                fault_l = 1;
                return pack_out(0, 0, 0, 0, 0, 1);
            end
            if (prev_err > 0)
                return pack_out(LOST_HIGH_PWM, LOST_LOW_PWM, 0, prev_turn, curve_f, 0);
            if (prev_err < 0)
                return pack_out(LOST_LOW_PWM, LOST_HIGH_PWM, 0, prev_turn, curve_f, 0);
            return pack_out(0, 0, 0, prev_turn, curve_f, 0);
        end
        lost_cnt = 0;
        err = round_div(sum * ONE, cnt);
        pd = longint'(kp_r) * err + longint'(kd_r) * (err - prev_err);
        pd = round_div(pd, ONE);
        if (negate_r) pd = -pd;
        lim = longint'(limit_r) * ONE;
        turn = clampv(pd, -lim, lim);
        lim = longint'(slew_r) * ONE;
        turn = clampv(turn, prev_turn - lim, prev_turn + lim);
        if (profile_r) begin
            update_detector(err, turn, ls, rs);
            bl = base_pwm(base_l);
            br = base_pwm(base_r);
        end else if (mag(err) >= thresh_r) begin
            bl = FAST_CURVE_L;
            br = FAST_CURVE_R;
        end else begin
            bl = FAST_STRAIGHT_L;
            br = FAST_STRAIGHT_R;
        end
        ti = turn / ONE;
        prev_turn = turn;
        prev_err = err;
        return pack_out(clampv(bl + ti, 0, 100), clampv(br - ti, 0, 100), 1, turn, curve_f, 0);
    endfunction

    // Offers one request, with a random idle gap in front of it.
    task automatic send_tick(logic [7:0] mask, logic [15:0] ls, logic [15:0] rs);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rs, ls, mask};
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(steer_tick(mask, longint'($signed(ls)), longint'($signed(rs))));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SPEED_PROFILE: profile_r = val[0];
            REG_KP_GAIN:       kp_r = val;
            REG_KD_GAIN:       kd_r = val;
            REG_CURVE_THRESH:  thresh_r = val[10:0];
            REG_STEER_LIMIT:   limit_r = val[6:0];
            REG_TURN_SLEW:     slew_r = val[6:0];
            REG_LOST_TIMEOUT:  timeout_r = val[7:0];
            default:           negate_r = val[0];
        endcase
    endtask

    task automatic set_regs(int p, int kp, int kd, int th, int lim, int sl, int to, int ng);
        wait_idle();
        write_reg(REG_SPEED_PROFILE, 12'(p));
        write_reg(REG_KP_GAIN, 12'(kp));
        write_reg(REG_KD_GAIN, 12'(kd));
        write_reg(REG_CURVE_THRESH, 12'(th));
        write_reg(REG_STEER_LIMIT, 12'(lim));
        write_reg(REG_TURN_SLEW, 12'(sl));
        write_reg(REG_LOST_TIMEOUT, 12'(to));
        write_reg(REG_STEER_NEGATE, 12'(ng));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_speed();
        if ($urandom_range(3) == 0) return 16'($urandom());
        return 16'($signed($urandom_range(400)) - 200);
    endfunction

    // Mostly a line under one to three adjacent sensors that drifts slowly,
    // sometimes a lost line or an arbitrary pattern.
    function automatic logic [7:0] rand_mask();
        int w;
        int r;
        r = $urandom_range(99);
        if (r < 6) return 8'h00;
        if (r < 14) return 8'($urandom());
        if ($urandom_range(2) == 0)
            pos = int'(clampv(longint'(pos) + longint'($urandom_range(2)) - 1, 0, 7));
        w = $urandom_range(3, 1);
        return 8'((((1 << w) - 1) << pos) & 8'hFF);
    endfunction

    task automatic test_directed();
        set_regs(0, 461, 38, 461, 20, 4, 20, 1);
        send_tick(8'h00, 16'h0000, 16'h0000);
        for (int i = 0; i < 8; i++) send_tick(8'(1 << i), 16'h7FFF, 16'h8000);
        send_tick(8'h00, 16'h8000, 16'h7FFF);
        send_tick(8'h01, 16'hFFFF, 16'h0001);
        send_tick(8'h00, 16'h0000, 16'h0000);
        send_tick(8'hFF, 16'h0000, 16'h0000);
        send_tick(8'h81, 16'h5555, 16'hAAAA);
        send_tick(8'h18, 16'hAAAA, 16'h5555);
        set_regs(1, 4095, 4095, 1792, 100, 100, 255, 0);
        send_tick(8'h80, 16'h0005, 16'h0000);
        send_tick(8'h01, 16'h7FFF, 16'h8000);
        send_tick(8'h7E, 16'h0000, 16'h7FFF);
        set_regs(0, 0, 0, 0, 0, 0, 0, 0);
        send_tick(8'h0F, 16'h0000, 16'h0000);
        send_tick(8'hF0, 16'h0000, 16'h0000);
    endtask

    // Lost line with the largest timeout: the counter saturates without a fault.
    task automatic test_lost_saturation();
        set_regs(0, 300, 100, 300, 30, 10, 255, 1);
        send_tick(8'h40, 16'h0000, 16'h0000);
        repeat (270) send_tick(8'h00, 16'($urandom()), 16'($urandom()));
        send_tick(8'h08, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_phase(int idle, int stall, int items);
        idle_pct = idle;
        stall_pct = stall;
        for (int p = 0; p < 2; p++) begin
            set_regs(p, $urandom_range(4095), $urandom_range(4095), $urandom_range(1792),
                     $urandom_range(100), $urandom_range(100), 255, $urandom_range(1));
            for (int n = 0; n < items; n++) begin
                // Straight runs let the curve detector leave a curve.
                if ($urandom_range(19) == 0) begin
                    repeat (30) send_tick(8'h18, 16'($urandom_range(60)), 16'($urandom_range(60)));
                    n += 29;
                end else begin
                    send_tick(rand_mask(), rand_speed(), rand_speed());
                end
            end
        end
    endtask

    // The receiver holds off while requests keep coming, then the sender
    // waits for every outstanding result.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        set_regs(1, 461, 38, 461, 20, 4, 255, 1);
        hold_requests++;
        repeat (20) send_tick(rand_mask(), rand_speed(), rand_speed());
        wait_idle();
        repeat (10) send_tick(rand_mask(), rand_speed(), rand_speed());
    endtask

    // The fault freezes the block until reset, so this test runs last.
    task automatic test_fault();
        idle_pct = 20;
        stall_pct = 20;
        set_regs(0, 461, 38, 461, 20, 4, 3, 1);
        send_tick(8'h02, 16'h0000, 16'h0000);
        repeat (6) send_tick(8'h00, 16'h0000, 16'h0000);
        send_tick(8'h18, 16'h0100, 16'h0100);
        send_tick(8'hFF, 16'h0100, 16'h0100);
    endtask

    // Receiver side: random stalls and a long hold-off on request.
    int hold_left = 0;
    int holds_seen = 0;
    always @(posedge aclk) begin
        if (hold_requests != holds_seen) begin
            holds_seen <= hold_requests;
            hold_left  <= 400;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
        m_tready <= (hold_left <= 1 && hold_requests == holds_seen) &&
                    ($urandom_range(99) >= stall_pct);
    end

    // Result checker.
    always @(posedge aclk) begin
        steer_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = steer_out_t'(m_tdata[32:0]);
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got.left !== want.left || got.right !== want.right ||
                    got.valid !== want.valid || got.steer !== want.steer ||
                    got.curve !== want.curve || got.fault !== want.fault) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected L%0d R%0d V%0d S%h C%0d F%0d, got L%0d R%0d V%0d S%h C%0d F%0d",
                                 want.left, want.right, want.valid, want.steer,
                                 want.curve, want.fault, got.left, got.right,
                                 got.valid, got.steer, got.curve, got.fault);
                end
            end
        end
    end

    // Watchdog.
    int cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        profile_r = 0; kp_r = 461; kd_r = 38; thresh_r = 461;
        limit_r = 20; slew_r = 4; timeout_r = 20; negate_r = 1;
        prev_err = 0; prev_turn = 0; filt_e = 0; filt_t = 0; filt_w = 0;
        base_l = BAL_STRAIGHT_L * ONE; base_r = BAL_STRAIGHT_R * ONE;
        lost_cnt = 0; enter_c = 0; exit_c = 0; fault_l = 0; curve_f = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_lost_saturation();
        test_random_phase(0, 0, 40);
        test_random_phase(66, 0, 40);
        test_random_phase(0, 66, 40);
        test_random_phase(37, 37, 40);
        test_backpressure();
        test_fault();
        wait_idle();
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
